// ===== sv/ordered_list_insert_delete_assert.svh =====
// Assertion macros for the ordered list block.
// Used by the top level only; no dependencies.
`ifndef ORDERED_LIST_INSERT_DELETE_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OLID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list assertion failed");

// Next-cycle implication, checked outside reset.
`define OLID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list assertion failed");

`endif

// ===== sv/olid_pkg.sv =====
// Shared constants, codes and types for the ordered list block.
// No dependencies; imported by olid_cell and ordered_list_insert_delete.
package olid_pkg;

    localparam int CAPACITY = 16;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    // Compare width: holds a position, a length and length + 1.
    localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
    localparam int WORD_W   = 32;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [LEN_W-1:0]  t_len;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     rd_sel;
    } t_cell_ctl;

endpackage

// ===== sv/olid_cell.sv =====
// One list entry: holds a word, shifts toward either neighbor or loads.
// Depends on olid_pkg.
module olid_cell (
    input  logic               i_clk,
    input  olid_pkg::t_cell_ctl i_ctl,
    input  olid_pkg::t_word    i_value,
    input  olid_pkg::t_word    i_left,
    input  olid_pkg::t_word    i_right,
    input  olid_pkg::t_word    i_rd_chain,
    output olid_pkg::t_word    o_data,
    output olid_pkg::t_word    o_rd_chain
);
    import olid_pkg::*;

    t_word r_data;
    t_word n_data;

    always_comb begin
        unique case (i_ctl.op)
            CELL_HOLD:       n_data = r_data;
            CELL_LOAD:       n_data = i_value;
            CELL_FROM_LEFT:  n_data = i_left;
            CELL_FROM_RIGHT: n_data = i_right;
            default:         n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    // Merge this entry into the read chain when selected.
    assign o_rd_chain = i_rd_chain | (i_ctl.rd_sel ? r_data : '0);

endmodule

// ===== sv/ordered_list_insert_delete.sv =====
// Top level of the ordered list: length counter, cell row, result register.
// Depends on olid_pkg, olid_cell and ordered_list_insert_delete_assert.svh.
//
//  channel | valid    | ready    | payload
//  --------+----------+----------+------------------------------------------
//  request | i_valid  | o_ready  | i_func, i_position, i_value
//  result  | o_valid  | i_ready  | o_status, o_length, o_spare, o_read_value
//
// Every request is handled in a single register update: the row of cells shifts
// all entries at once, so one request per clock is sustained while results
// are taken; the result register is loaded at the accepting edge.
// Reset (i_rst_n low, synchronous) clears the length and the result valid;
// entry words carry no reset and are only read within the length.
// A stalled result holds the register; a new request is taken in the cycle
// the held result leaves.
module ordered_list_insert_delete (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_position,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [4:0]  o_length,
    output logic [4:0]  o_spare,
    output logic [31:0] o_read_value
);
    import olid_pkg::*;

    `include "ordered_list_insert_delete_assert.svh"

    // Control and result registers.
    t_len        r_len;
    t_len        n_len;
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [1:0]  n_status;
    logic [4:0]  r_length;
    logic [4:0]  r_spare;
    t_word       r_read_value;

    logic             accept;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] pos_m1;
    logic [CMP_W-1:0] len_ext;
    logic             pos_nonzero;
    logic             full;
    logic             ins_ok;
    logic             del_ok;
    logic             rd_ok;

    t_word     w_data  [CAPACITY];
    t_word     w_chain [CAPACITY+1];
    t_cell_ctl w_ctl   [CAPACITY];

    // The result register frees up when its content is taken.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Position checks against the current length.
    assign pos_ext     = CMP_W'(i_position);
    assign pos_m1      = pos_ext - CMP_W'(1);
    assign len_ext     = CMP_W'(r_len);
    assign pos_nonzero = (i_position != '0);
    assign full        = (len_ext >= CMP_W'(CAPACITY));
    assign ins_ok = accept && (i_func == FUNC_INSERT) && !full && pos_nonzero
                    && (pos_ext <= len_ext + CMP_W'(1));
    assign del_ok = accept && (i_func == FUNC_DELETE) && pos_nonzero
                    && (pos_ext <= len_ext);
    assign rd_ok  = accept && (i_func == FUNC_READ) && pos_nonzero
                    && (pos_ext <= len_ext);

    always_comb begin
        n_len = r_len;
        if (ins_ok) begin
            n_len = r_len + LEN_W'(1);
        end else if (del_ok) begin
            n_len = r_len - LEN_W'(1);
        end
    end

    always_comb begin
        unique case (i_func)
            FUNC_INSERT: n_status = full ? ST_FULL : (ins_ok ? ST_DONE : ST_ILLEGAL);
            FUNC_DELETE: n_status = del_ok ? ST_DONE : ST_ILLEGAL;
            FUNC_READ:   n_status = rd_ok ? ST_DONE : ST_ILLEGAL;
            default:     n_status = ST_ILLEGAL;
        endcase
    end

    // Row of cells. Cell g holds list position g + 1. Insert moves cells
    // above the slot up and loads the slot; delete pulls cells from the
    // slot upward down by one; the top cell holds on delete.
    assign w_chain[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CMP_W-1:0] CELL_IDX = CMP_W'(g);
        t_word w_left;
        t_word w_right;

        always_comb begin
            w_ctl[g].op     = CELL_HOLD;
            w_ctl[g].rd_sel = rd_ok && (CELL_IDX == pos_m1);
            if (ins_ok) begin
                if (CELL_IDX == pos_m1) begin
                    w_ctl[g].op = CELL_LOAD;
                end else if (CELL_IDX > pos_m1) begin
                    w_ctl[g].op = CELL_FROM_LEFT;
                end
            end else if (del_ok && (CELL_IDX >= pos_m1)) begin
                w_ctl[g].op = CELL_FROM_RIGHT;
            end
        end

        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_inner_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner_r
            assign w_right = w_data[g+1];
        end

        olid_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[g]),
            .i_value    (i_value),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_rd_chain (w_chain[g]),
            .o_data     (w_data[g]),
            .o_rd_chain (w_chain[g+1])
        );
    end

    // Advance length and result; hold the result while it is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len <= n_len;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= n_status;
            r_length     <= 5'(n_len);
            r_spare      <= 5'(LEN_W'(CAPACITY) - n_len);
            r_read_value <= w_chain[CAPACITY];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_length     = r_length;
    assign o_spare      = r_spare;
    assign o_read_value = r_read_value;

    // Length never runs past the store.
    `OLID_ASSERT_NOW(a_len_in_range, i_clk, i_rst_n, 1'b1, r_len <= LEN_W'(CAPACITY))
    // An accepted request always leaves a result behind.
    `OLID_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, accept, r_out_valid)
    // A full report means the list really is full while the report is shown.
    `OLID_ASSERT_NOW(a_full_only_when_full, i_clk, i_rst_n,
        r_out_valid && (r_status == ST_FULL), r_len == LEN_W'(CAPACITY))
    // Length and spare always add up to the capacity.
    `OLID_ASSERT_NOW(a_len_spare_sum, i_clk, i_rst_n, r_out_valid,
        5'(r_length + r_spare) == 5'(CAPACITY))

endmodule
